[rtl/core/matc_pkg.sv]
// Shared types, constants and helper functions of the marker approach thrust controller.
package matc_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned ERR_W   = 17;
    localparam int unsigned RATE_W  = 22;
    localparam int unsigned ACC_W   = 27;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned THR_W   = 24;
    localparam int unsigned MAC_W   = 58;
    localparam int unsigned INNER_W = 41;
    localparam int unsigned OPND_W  = 33;
    localparam int unsigned PROD_W  = 50;
    localparam int unsigned SAT_W   = 22;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned TOL_W   = 15;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] WARMUP_DEF     = 16'd30;
    localparam logic [CNT_W-1:0] SETTLE_DEF     = 16'd30;
    localparam logic [TOL_W-1:0] TOLERANCE_DEF  = 15'd205;
    localparam logic [SAT_W-1:0] SAT_HOLD_DEF   = 22'd2048;
    localparam logic [SAT_W-1:0] SAT_APPR_DEF   = 22'd2048;
    localparam logic signed [POS_W-1:0] YAW_DEADBAND = 16'sd41;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_LAW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PID_P      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PID_I      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PID_D      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TDC_M      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TDC_K      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TDC_V      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_SQ    = 3'd7;

    // side command codes
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_TURN1 = 2'd1;
    localparam logic [1:0] SIDE_TURN2 = 2'd2;
    localparam logic [1:0] SIDE_WINCH = 2'd3;

    // modes
    localparam logic signed [3:0] MODE_IDLE  = 4'sd0;
    localparam logic signed [3:0] MODE_LOW   = -4'sd2;
    localparam logic signed [3:0] MODE_WINCH = 4'sd4;

    // multiply-accumulate operand selection
    localparam logic [2:0] MAC_SQ  = 3'd0;
    localparam logic [2:0] MAC_PE  = 3'd1;
    localparam logic [2:0] MAC_DR  = 3'd2;
    localparam logic [2:0] MAC_IS  = 3'd3;
    localparam logic [2:0] MAC_VR  = 3'd4;
    localparam logic [2:0] MAC_KE  = 3'd5;
    localparam logic [2:0] MAC_MLO = 3'd6;
    localparam logic [2:0] MAC_MHI = 3'd7;

    typedef struct packed {
        logic                    command;
        logic signed [3:0]       new_mode;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] heading;
        logic                    sample_ok;
    } in_t;

    typedef struct packed {
        logic signed [THR_W-1:0] thrust_front_a;
        logic signed [THR_W-1:0] thrust_front_b;
        logic signed [THR_W-1:0] thrust_rear_a;
        logic signed [THR_W-1:0] thrust_rear_b;
        logic                    thrust_valid;
        logic [1:0]              side_command;
        logic                    target_reset;
        logic                    calibrate_flag;
        logic signed [3:0]       mode_now;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       mac_en;
        logic       mac_clr;
        logic [2:0] mac_sel;
        logic [1:0] sq_idx;
        logic       gate;
        logic       err;
        logic       rate;
        logic       accel;
        logic       inner;
        logic       thr;
        logic       axis;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic is_cmd;
        logic is_ok;
        logic run;
        logic law;
        logic out_hold;
    } status_t;

    typedef struct packed {
        logic                    valid;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] tz;
        logic                    hold;
        logic                    yaw;
        logic                    rst;
        logic signed [3:0]       next;
    } row_t;

    function automatic row_t matc_row(input logic signed [3:0] m);
        row_t r;
        r = '0;
        case (m)
            -4'sd1: r = '{1'b1, 16'sd410, 16'sd5325, 1'b1, 1'b0, 1'b0, 4'sd0};
            -4'sd2: r = '{1'b1, 16'sd410, 16'sd2458, 1'b1, 1'b0, 1'b0, 4'sd0};
            4'sd1:  r = '{1'b1, 16'sd0,   16'sd4096, 1'b0, 1'b1, 1'b1, 4'sd0};
            4'sd2:  r = '{1'b1, 16'sd164, 16'sd2458, 1'b0, 1'b1, 1'b0, 4'sd3};
            4'sd3:  r = '{1'b1, 16'sd164, 16'sd1229, 1'b0, 1'b1, 1'b0, 4'sd4};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [RATE_W-1:0] sat22(input logic signed [RATE_W:0] v);
        if (v > 23'sd2097151)       return 22'sh1FFFFF;
        else if (v < -23'sd2097152) return 22'sh200000;
        else                        return v[RATE_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat27(input logic signed [ACC_W:0] v);
        if (v > 28'sd67108863)       return 27'sh3FFFFFF;
        else if (v < -28'sd67108864) return 27'sh4000000;
        else                         return v[ACC_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat32(input logic signed [SUM_W:0] v);
        if (v > 33'sh0_7FFF_FFFF)      return 32'sh7FFF_FFFF;
        else if (v < -33'sh0_8000_0000) return 32'sh8000_0000;
        else                           return v[SUM_W-1:0];
    endfunction

endpackage

[rtl/core/matc_ctrl.sv]
// Sequencing state machine of the marker approach thrust controller.
module matc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  matc_pkg::status_t status,
    output matc_pkg::cmd_t    cmd
);
    import matc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DISP  = 4'd1;
    localparam logic [3:0] ST_SQ0   = 4'd2;
    localparam logic [3:0] ST_SQ1   = 4'd3;
    localparam logic [3:0] ST_SQ2   = 4'd4;
    localparam logic [3:0] ST_GATE  = 4'd5;
    localparam logic [3:0] ST_ERR   = 4'd6;
    localparam logic [3:0] ST_RATE  = 4'd7;
    localparam logic [3:0] ST_ACC   = 4'd8;
    localparam logic [3:0] ST_M1    = 4'd9;
    localparam logic [3:0] ST_M2    = 4'd10;
    localparam logic [3:0] ST_M3    = 4'd11;
    localparam logic [3:0] ST_INNER = 4'd12;
    localparam logic [3:0] ST_MLO   = 4'd13;
    localparam logic [3:0] ST_MHI   = 4'd14;
    localparam logic [3:0] ST_THR   = 4'd15;
    localparam logic [3:0] ST_FIN   = 4'd1;

    logic [3:0] state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       axis_reg, axis_next;

    always_comb
    begin
        cmd          = '0;
        cmd.axis     = axis_reg;
        state_next   = state_reg;
        fin_next     = fin_reg;
        axis_next    = axis_reg;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    fin_next   = 1'b0;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                // this code doubles as the finishing step once fin_reg is set
                if (fin_reg)
                begin
                    if (!status.out_hold)
                    begin
                        cmd.finish = 1'b1;
                        fin_next   = 1'b0;
                        axis_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.is_cmd || !status.is_ok)
                    fin_next = 1'b1;
                else
                    state_next = ST_SQ0;
            end
            ST_SQ0:
            begin
                cmd.mac_en = 1'b1; cmd.mac_clr = 1'b1; cmd.mac_sel = MAC_SQ; cmd.sq_idx = 2'd0;
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.mac_en = 1'b1; cmd.mac_sel = MAC_SQ; cmd.sq_idx = 2'd1;
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.mac_en = 1'b1; cmd.mac_sel = MAC_SQ; cmd.sq_idx = 2'd2;
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                cmd.gate = 1'b1;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.err = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.rate = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accel = 1'b1;
                if (status.run)
                    state_next = ST_M1;
                else
                begin
                    fin_next   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_M1:
            begin
                cmd.mac_en = 1'b1; cmd.mac_clr = 1'b1;
                cmd.mac_sel = status.law ? MAC_VR : MAC_PE;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.mac_en = 1'b1;
                cmd.mac_sel = status.law ? MAC_KE : MAC_DR;
                state_next = status.law ? ST_INNER : ST_M3;
            end
            ST_M3:
            begin
                cmd.mac_en = 1'b1; cmd.mac_sel = MAC_IS;
                state_next = ST_THR;
            end
            ST_INNER:
            begin
                cmd.inner = 1'b1;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.mac_en = 1'b1; cmd.mac_clr = 1'b1; cmd.mac_sel = MAC_MLO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mac_en = 1'b1; cmd.mac_sel = MAC_MHI;
                state_next = ST_THR;
            end
            ST_THR:
            begin
                cmd.thr = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_M1;
                end
                else
                begin
                    fin_next   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

[rtl/core/matc_dp.sv]
// Datapath of the marker approach thrust controller: state, multiplier and result register.
module matc_dp #(
    parameter logic [15:0] WARMUP_SAMPLES   = matc_pkg::WARMUP_DEF,
    parameter logic [15:0] SETTLE_SAMPLES   = matc_pkg::SETTLE_DEF,
    parameter logic [14:0] SETTLE_TOLERANCE = matc_pkg::TOLERANCE_DEF,
    parameter logic [21:0] SAT_HOLD         = matc_pkg::SAT_HOLD_DEF,
    parameter logic [21:0] SAT_APPROACH     = matc_pkg::SAT_APPR_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  matc_pkg::in_t                        sample,
    input  logic                                 cfg_write,
    input  logic [matc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data,
    input  matc_pkg::cmd_t                       cmd,
    output matc_pkg::status_t                    status,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output matc_pkg::out_t                       result
);
    import matc_pkg::*;

    // configuration
    logic        law_reg;
    logic [15:0] gp_reg, gi_reg, gd_reg, gm_reg, gk_reg, gv_reg;
    logic [31:0] jump_reg;

    // persistent state
    logic signed [3:0]         mode_reg;
    logic signed [POS_W-1:0]   last_reg [3];
    logic signed [ERR_W-1:0]   perr_reg [2];
    logic signed [RATE_W-1:0]  prate_reg [2];
    logic signed [ACC_W-1:0]   pacc_reg [2];
    logic signed [SUM_W-1:0]   esum_reg [2];
    logic signed [THR_W-1:0]   thr_reg [2];
    logic [CNT_W-1:0]          samp_reg, settle_reg;

    // per-item working registers
    in_t                       item_reg;
    logic signed [POS_W-1:0]   p_reg [3];
    logic signed [ERR_W-1:0]   e_reg [2];
    logic signed [SUM_W-1:0]   snew_reg [2];
    logic signed [RATE_W-1:0]  rate_reg [2];
    logic signed [ACC_W-1:0]   acc_reg [2];
    logic                      conv_reg;
    logic signed [MAC_W-1:0]   mac_reg;
    logic signed [INNER_W-1:0] inner_reg;
    logic signed [THR_W-1:0]   t_reg [2];

    logic  result_valid_reg;
    out_t  result_reg;

    row_t  row;
    logic  k;
    assign row = matc_row(mode_reg);
    assign k   = ~cmd.axis;

    assign status.is_cmd   = item_reg.command;
    assign status.is_ok    = item_reg.sample_ok;
    assign status.run      = row.valid;
    assign status.law      = law_reg;
    assign status.out_hold = result_valid_reg && !result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // shared multiplier: unsigned 16-bit gain or distance by signed 33-bit operand
    logic signed [POS_W-1:0]   sq_pos, sq_last;
    logic signed [ERR_W-1:0]   sq_d;
    logic [ERR_W-1:0]          sq_abs;
    logic [15:0]               mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [MAC_W-1:0]   addend;

    always_comb
    begin
        case (cmd.sq_idx)
            2'd0:    begin sq_pos = item_reg.pos_x; sq_last = last_reg[0]; end
            2'd1:    begin sq_pos = item_reg.pos_y; sq_last = last_reg[1]; end
            default: begin sq_pos = item_reg.pos_z; sq_last = last_reg[2]; end
        endcase
        sq_d   = ERR_W'(sq_last) - ERR_W'(sq_pos);
        sq_abs = sq_d[ERR_W-1] ? ERR_W'(-sq_d) : ERR_W'(sq_d);
        case (cmd.mac_sel)
            MAC_SQ:  begin mul_a = sq_abs[15:0]; mul_b = OPND_W'({1'b0, sq_abs[15:0]}); end
            MAC_PE:  begin mul_a = gp_reg; mul_b = OPND_W'(e_reg[k]); end
            MAC_DR:  begin mul_a = gd_reg; mul_b = OPND_W'(rate_reg[k]); end
            MAC_IS:  begin mul_a = gi_reg; mul_b = OPND_W'(snew_reg[k]); end
            MAC_VR:  begin mul_a = gv_reg; mul_b = OPND_W'(rate_reg[k]); end
            MAC_KE:  begin mul_a = gk_reg; mul_b = OPND_W'(e_reg[k]); end
            MAC_MLO: begin mul_a = gm_reg; mul_b = OPND_W'({1'b0, inner_reg[19:0]}); end
            default:
            begin
                mul_a = gm_reg;
                mul_b = OPND_W'($signed(inner_reg[INNER_W-1:20]));
            end
        endcase
        prod   = $signed({1'b0, mul_a}) * mul_b;
        addend = (cmd.mac_sel == MAC_MHI) ? (MAC_W'(prod) <<< 20) : MAC_W'(prod);
    end

    // error terms
    logic signed [ERR_W-1:0] ex, ey, ez;
    logic [ERR_W-1:0]        ax, ay, az;
    assign ex = ERR_W'(0) - ERR_W'(p_reg[0]);
    assign ey = ERR_W'(row.ty) - ERR_W'(p_reg[1]);
    assign ez = ERR_W'(row.tz) - ERR_W'(p_reg[2]);
    assign ax = ex[ERR_W-1] ? ERR_W'(-ex) : ERR_W'(ex);
    assign ay = ey[ERR_W-1] ? ERR_W'(-ey) : ERR_W'(ey);
    assign az = ez[ERR_W-1] ? ERR_W'(-ez) : ERR_W'(ez);

    logic signed [ERR_W:0]    rd [2];
    logic signed [RATE_W:0]   rx30 [2];
    logic signed [RATE_W:0]   ad [2];
    logic signed [ACC_W:0]    ax30 [2];
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rd[i]   = (ERR_W+1)'(e_reg[i]) - (ERR_W+1)'(perr_reg[i]);
            rx30[i] = ((RATE_W+1)'(rd[i]) <<< 5) - ((RATE_W+1)'(rd[i]) <<< 1);
            ad[i]   = (RATE_W+1)'(rate_reg[i]) - (RATE_W+1)'(prate_reg[i]);
            ax30[i] = ((ACC_W+1)'(ad[i]) <<< 5) - ((ACC_W+1)'(ad[i]) <<< 1);
        end
    end

    // thrust of the current axis
    logic signed [59:0]        tv;
    logic signed [59:0]        lim;
    logic signed [THR_W-1:0]   tclamp;
    always_comb
    begin
        lim = 60'(signed'({1'b0, (row.hold ? SAT_HOLD : SAT_APPROACH)}));
        if (!law_reg)
            tv = 60'(-(60'(mac_reg))) >>> 8;
        else
            tv = 60'(thr_reg[cmd.axis]) - (60'(mac_reg) >>> 16);
        if (tv > lim)        tclamp = THR_W'(lim);
        else if (tv < -lim)  tclamp = THR_W'(-lim);
        else                 tclamp = THR_W'(tv);
    end

    // finishing step
    out_t                res;
    logic signed [3:0]   mode_n;
    logic [CNT_W-1:0]    samp_n, settle_n, settle_inc;
    logic                upd_run, aligned;
    always_comb
    begin
        res        = '0;
        mode_n     = mode_reg;
        samp_n     = samp_reg;
        settle_n   = settle_reg;
        settle_inc = (settle_reg == '1) ? settle_reg : settle_reg + 1'b1;
        upd_run    = 1'b0;
        aligned    = 1'b0;
        if (item_reg.command)
        begin
            if (item_reg.new_mode >= MODE_LOW && item_reg.new_mode <= MODE_WINCH)
                mode_n = item_reg.new_mode;
            else
                mode_n = MODE_IDLE;
        end
        else if (item_reg.sample_ok)
        begin
            if (mode_reg == MODE_WINCH)
            begin
                res.side_command = SIDE_WINCH;
                res.target_reset = 1'b1;
                mode_n   = MODE_IDLE;
                settle_n = '0;
            end
            else if (row.valid)
            begin
                upd_run = 1'b1;
                samp_n  = (samp_reg == '1) ? samp_reg : samp_reg + 1'b1;
                if (samp_n > WARMUP_SAMPLES)
                begin
                    res.thrust_front_a = t_reg[1] - t_reg[0];
                    res.thrust_front_b = -t_reg[0] - t_reg[1];
                    res.thrust_rear_a  = t_reg[0] - t_reg[1];
                    res.thrust_rear_b  = t_reg[0] + t_reg[1];
                    res.thrust_valid   = 1'b1;
                end
                if (row.yaw)
                begin
                    if (item_reg.heading >= YAW_DEADBAND)
                        res.side_command = SIDE_TURN1;
                    else if (item_reg.heading <= -YAW_DEADBAND)
                        res.side_command = SIDE_TURN2;
                    else
                        aligned = 1'b1;
                end
                if (conv_reg)
                begin
                    settle_n = settle_inc;
                    if (settle_inc > SETTLE_SAMPLES && (!row.yaw || aligned))
                    begin
                        if (row.rst)
                        begin
                            mode_n   = MODE_IDLE;
                            settle_n = '0;
                            res.target_reset   = 1'b1;
                            res.calibrate_flag = 1'b1;
                        end
                        else if (row.next != MODE_IDLE)
                        begin
                            mode_n   = row.next;
                            settle_n = '0;
                        end
                    end
                end
            end
        end
        res.mode_now = mode_n;
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg  <= 1'b0;
            gp_reg   <= '0; gi_reg <= '0; gd_reg <= '0;
            gm_reg   <= '0; gk_reg <= '0; gv_reg <= '0;
            jump_reg <= '1;
            mode_reg <= MODE_IDLE;
            samp_reg <= '0;
            settle_reg <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) last_reg[i] <= '0;
            for (int i = 0; i < 2; i++)
            begin
                perr_reg[i]  <= '0;
                prate_reg[i] <= '0;
                pacc_reg[i]  <= '0;
                esum_reg[i]  <= '0;
                thr_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_THRUST_LAW: law_reg  <= cfg_data[0];
                    CFG_PID_P:      gp_reg   <= cfg_data[15:0];
                    CFG_PID_I:      gi_reg   <= cfg_data[15:0];
                    CFG_PID_D:      gd_reg   <= cfg_data[15:0];
                    CFG_TDC_M:      gm_reg   <= cfg_data[15:0];
                    CFG_TDC_K:      gk_reg   <= cfg_data[15:0];
                    CFG_TDC_V:      gv_reg   <= cfg_data[15:0];
                    CFG_JUMP_SQ:    jump_reg <= cfg_data;
                    default:        law_reg  <= law_reg;
                endcase
            end
            if (cmd.gate)
            begin
                // accept the sample unless it jumps too far after warmup
                if (!(mac_reg > MAC_W'({1'b0, jump_reg}) && samp_reg > WARMUP_SAMPLES))
                begin
                    last_reg[0] <= item_reg.pos_x;
                    last_reg[1] <= item_reg.pos_y;
                    last_reg[2] <= item_reg.pos_z;
                end
            end
            if (cmd.thr)
                thr_reg[cmd.axis] <= tclamp;
            if (cmd.finish)
            begin
                mode_reg   <= mode_n;
                samp_reg   <= samp_n;
                settle_reg <= settle_n;
                if (upd_run)
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        perr_reg[i]  <= e_reg[i];
                        prate_reg[i] <= rate_reg[i];
                        esum_reg[i]  <= snew_reg[i];
                        pacc_reg[i]  <= (mode_reg < MODE_IDLE) ?
                                        sat27(-((ACC_W+1)'(acc_reg[i]))) : acc_reg[i];
                    end
                end
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= sample;
        if (cmd.mac_en)
            mac_reg <= (cmd.mac_clr ? MAC_W'(0) : mac_reg) + addend;
        if (cmd.gate)
        begin
            if (mac_reg > MAC_W'({1'b0, jump_reg}) && samp_reg > WARMUP_SAMPLES)
            begin
                p_reg[0] <= last_reg[0];
                p_reg[1] <= last_reg[1];
                p_reg[2] <= last_reg[2];
            end
            else
            begin
                p_reg[0] <= item_reg.pos_x;
                p_reg[1] <= item_reg.pos_y;
                p_reg[2] <= item_reg.pos_z;
            end
        end
        if (cmd.err)
        begin
            e_reg[0]    <= ex;
            e_reg[1]    <= ez;
            snew_reg[0] <= sat32((SUM_W+1)'(esum_reg[0]) + (SUM_W+1)'(ex));
            snew_reg[1] <= sat32((SUM_W+1)'(esum_reg[1]) + (SUM_W+1)'(ez));
            conv_reg    <= (ax < ERR_W'(SETTLE_TOLERANCE)) && (ay < ERR_W'(SETTLE_TOLERANCE))
                        && (az < ERR_W'(SETTLE_TOLERANCE));
        end
        if (cmd.rate)
            for (int i = 0; i < 2; i++) rate_reg[i] <= sat22(rx30[i]);
        if (cmd.accel)
            for (int i = 0; i < 2; i++) acc_reg[i] <= sat27(ax30[i]);
        if (cmd.inner)
            inner_reg <= INNER_W'(mac_reg) - (INNER_W'(pacc_reg[k]) <<< 8);
        if (cmd.thr)
            t_reg[cmd.axis] <= tclamp;
        if (cmd.finish)
            result_reg <= res;
    end

endmodule

[rtl/core/marker_approach_thrust_controller.sv]
// Top level of the marker approach thrust controller: controller, datapath and port wiring.
// A mode command or an invalid sample goes straight from load to finish; a valid sample
// runs the distance squares, outlier gate and error, rate and acceleration steps, and in
// a mode with a control row both thrust axes under PID or time-delay control; one item
// is in flight at a time, as sample_ready is high only in the idle state, so the next beat waits.
// A finished result waits in the output register while the next sample beat is taken.
// rst_n clears mode, history, counters and configuration (jump limit to all ones) at once.
module marker_approach_thrust_controller #(
    parameter logic [15:0] WARMUP_SAMPLES   = matc_pkg::WARMUP_DEF,
    parameter logic [15:0] SETTLE_SAMPLES   = matc_pkg::SETTLE_DEF,
    parameter logic [14:0] SETTLE_TOLERANCE = matc_pkg::TOLERANCE_DEF,
    parameter logic [21:0] SAT_HOLD         = matc_pkg::SAT_HOLD_DEF,
    parameter logic [21:0] SAT_APPROACH     = matc_pkg::SAT_APPR_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  matc_pkg::in_t                  sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output matc_pkg::out_t                 result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [matc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import matc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // configuration must be written only while idle (the block does not enforce this), so take every beat at once
    assign cfg_ready = 1'b1;

    // sequence the steps: distance squares, outlier gate, error, rate and acceleration terms, two thrust axes, finish
    matc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // hold all state and the result register; advance on each command
    matc_dp #(
        .WARMUP_SAMPLES   (WARMUP_SAMPLES),
        .SETTLE_SAMPLES   (SETTLE_SAMPLES),
        .SETTLE_TOLERANCE (SETTLE_TOLERANCE),
        .SAT_HOLD         (SAT_HOLD),
        .SAT_APPROACH     (SAT_APPROACH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/core/matc_checker.sv]
// Port-level checks of the marker approach thrust controller, bound to the top level.
module matc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           result_valid,
    input logic                           result_ready,
    input matc_pkg::out_t                 result
);
    import matc_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result payload changed while stalled");

    a_thrust_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.thrust_valid |->
            result.thrust_front_a == 0 && result.thrust_front_b == 0 &&
            result.thrust_rear_a == 0 && result.thrust_rear_b == 0)
        else $error("thrust present without thrust_valid");

    a_winch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.side_command == SIDE_WINCH |->
            result.target_reset && !result.calibrate_flag && result.mode_now == MODE_IDLE)
        else $error("winch deploy without reset to idle");

    a_calib: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.calibrate_flag |->
            result.target_reset && result.mode_now == MODE_IDLE)
        else $error("calibration flag without target reset");

endmodule

bind marker_approach_thrust_controller matc_checker u_matc_checker (.*);

[bench/marker_approach_thrust_controller_tb.sv]
// Self-checking testbench for the marker approach thrust controller.
module marker_approach_thrust_controller_tb;
    import matc_pkg::*;

    // Approach modes; the package names only -2 (MODE_LOW) and 4 (MODE_WINCH) among them
    localparam int MODE_HOLD_HIGH = -1;
    localparam int MODE_HOLD_LOW  = -2;
    localparam int MODE_ALIGN     = 1;
    localparam int MODE_NEAR      = 2;
    localparam int MODE_FINAL     = 3;
    localparam int MODE_DEPLOY    = 4;

    // Item kinds
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    localparam int  WARMUP     = 30;
    localparam int  SETTLE     = 30;
    localparam int  TOLERANCE  = 205;
    localparam int  DEADBAND   = 41;
    localparam int  SAT_H      = 2048;
    localparam int  SAT_A      = 2048;
    localparam int  RATE_HZ    = 30;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  SETTLE_GAP = 40;

    logic   clk;
    logic   rst_n;
    logic   sample_valid;
    logic   sample_ready;
    in_t    sample;
    logic   result_valid;
    logic   result_ready;
    out_t   result;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    marker_approach_thrust_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Controller image: configuration and state held by the predictor
    longint law_sel, gain_p, gain_i, gain_d, tdc_m, tdc_k, tdc_v, jump_sq;
    int     ctl_mode;
    longint good_pos [3];
    longint last_err [2];
    longint last_rate [2];
    longint last_acc [2];
    longint err_sum [2];
    longint thrust_xy [2];
    int     sample_cnt;
    int     settle_cnt;

    out_t   pending_results [$];
    int     mismatches;
    bit     failed;
    int     cycle_cnt;
    bit     eager;
    int     hold_left;
    int     rx_wait;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate to a signed width
    function automatic longint sat_to(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Mode table row: returns 0 for modes without a control row
    function automatic bit mode_row(input int m, output longint ty, output longint tz,
                                    output longint lim, output bit yaw, output bit recal,
                                    output int nxt);
        ty = 0; tz = 0; lim = SAT_A; yaw = 1'b1; recal = 1'b0; nxt = 0;
        case (m)
            MODE_HOLD_HIGH:
            begin
                ty = 410; tz = 5325; lim = SAT_H; yaw = 1'b0;
            end
            MODE_HOLD_LOW:
            begin
                ty = 410; tz = 2458; lim = SAT_H; yaw = 1'b0;
            end
            MODE_ALIGN:
            begin
                tz = 4096; recal = 1'b1;
            end
            MODE_NEAR:
            begin
                ty = 164; tz = 2458; nxt = MODE_FINAL;
            end
            MODE_FINAL:
            begin
                ty = 164; tz = 1229; nxt = MODE_DEPLOY;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void reset_controller();
        law_sel = 0; gain_p = 0; gain_i = 0; gain_d = 0;
        tdc_m = 0; tdc_k = 0; tdc_v = 0; jump_sq = 64'hFFFF_FFFF;
        ctl_mode = 0;
        for (int i = 0; i < 3; i++)
            good_pos[i] = 0;
        for (int i = 0; i < 2; i++)
        begin
            last_err[i] = 0; last_rate[i] = 0; last_acc[i] = 0;
            err_sum[i] = 0; thrust_xy[i] = 0;
        end
        sample_cnt = 0;
        settle_cnt = 0;
    endfunction

    // Advance the controller image by one item and return the result it yields
    function automatic out_t predict_controller(in_t s);
        out_t   r;
        longint p [3];
        longint e [2];
        longint rt [2];
        longint ac [2];
        longint t [2];
        longint d, dsq, v, ey, ty, tz, lim;
        bit     yaw, recal, aligned;
        int     nxt, nm, k;
        r = '0;
        if (s.command == CMD_SET_MODE)
        begin
            nm = s.new_mode;
            ctl_mode = (nm >= MODE_HOLD_LOW && nm <= MODE_DEPLOY) ? nm : 0;
        end
        else if (s.sample_ok)
        begin
            p[0] = s.pos_x; p[1] = s.pos_y; p[2] = s.pos_z;
            dsq = 0;
            for (int i = 0; i < 3; i++)
            begin
                d = good_pos[i] - p[i];
                dsq += d * d;
            end
            if (dsq > jump_sq && sample_cnt > WARMUP)
                for (int i = 0; i < 3; i++)
                    p[i] = good_pos[i];
            else
                for (int i = 0; i < 3; i++)
                    good_pos[i] = p[i];
            if (ctl_mode == MODE_DEPLOY)
            begin
                r.side_command = SIDE_WINCH;
                r.target_reset = 1'b1;
                ctl_mode = 0;
                settle_cnt = 0;
            end
            else if (mode_row(ctl_mode, ty, tz, lim, yaw, recal, nxt))
            begin
                aligned = 1'b0;
                e[0] = -p[0];
                e[1] = tz - p[2];
                ey = ty - p[1];
                for (int i = 0; i < 2; i++)
                begin
                    err_sum[i] = sat_to(err_sum[i] + e[i], 32);
                    rt[i] = sat_to((e[i] - last_err[i]) * RATE_HZ, 22);
                    ac[i] = sat_to((rt[i] - last_rate[i]) * RATE_HZ, 27);
                end
                // Tx is driven by the z error, Ty by the x error
                for (int i = 0; i < 2; i++)
                begin
                    k = 1 - i;
                    if (law_sel == 0)
                    begin
                        v = gain_p * e[k] + gain_d * rt[k] + gain_i * err_sum[k];
                        v = (-v) >>> 8;
                    end
                    else
                    begin
                        v = -last_acc[k] * 256 + tdc_v * rt[k] + tdc_k * e[k];
                        v = thrust_xy[i] - ((tdc_m * v) >>> 16);
                    end
                    t[i] = clamp_mag(v, lim);
                    thrust_xy[i] = t[i];
                end
                if (sample_cnt < 65535)
                    sample_cnt++;
                if (sample_cnt > WARMUP)
                begin
                    r.thrust_front_a = 24'(t[1] - t[0]);
                    r.thrust_front_b = 24'(-t[0] - t[1]);
                    r.thrust_rear_a  = 24'(t[0] - t[1]);
                    r.thrust_rear_b  = 24'(t[0] + t[1]);
                    r.thrust_valid   = 1'b1;
                end
                for (int i = 0; i < 2; i++)
                begin
                    last_acc[i]  = (ctl_mode < 0) ? sat_to(-ac[i], 27) : ac[i];
                    last_err[i]  = e[i];
                    last_rate[i] = rt[i];
                end
                if (yaw)
                begin
                    if (s.heading >= DEADBAND)
                        r.side_command = SIDE_TURN1;
                    else if (s.heading <= -DEADBAND)
                        r.side_command = SIDE_TURN2;
                    else
                        aligned = 1'b1;
                end
                if (abs_of(e[0]) < TOLERANCE && abs_of(ey) < TOLERANCE
                    && abs_of(e[1]) < TOLERANCE)
                begin
                    if (settle_cnt < 65535)
                        settle_cnt++;
                    if (settle_cnt > SETTLE && (!yaw || aligned))
                    begin
                        if (recal)
                        begin
                            ctl_mode = 0;
                            settle_cnt = 0;
                            r.target_reset = 1'b1;
                            r.calibrate_flag = 1'b1;
                        end
                        else if (nxt != 0)
                        begin
                            ctl_mode = nxt;
                            settle_cnt = 0;
                        end
                    end
                end
            end
        end
        r.mode_now = 4'(ctl_mode);
        return r;
    endfunction

    // Count a mismatch; report only the first few
    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", name, want, got);
        end
    endfunction

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("marker_approach_thrust_controller test failed");
            $finish;
        end
    end

    // Long receiver hold-off, counted down on its own
    always @(posedge clk)
        if (hold_left > 0)
            hold_left <= hold_left - 1;

    // Result side: accept, compare with the oldest prediction, then draw a stall
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat, mode_now %0d", result.mode_now);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("thrust_front_a", want.thrust_front_a, result.thrust_front_a);
                    check_field("thrust_front_b", want.thrust_front_b, result.thrust_front_b);
                    check_field("thrust_rear_a", want.thrust_rear_a, result.thrust_rear_a);
                    check_field("thrust_rear_b", want.thrust_rear_b, result.thrust_rear_b);
                    check_field("thrust_valid", want.thrust_valid, result.thrust_valid);
                    check_field("side_command", want.side_command, result.side_command);
                    check_field("target_reset", want.target_reset, result.target_reset);
                    check_field("calibrate_flag", want.calibrate_flag, result.calibrate_flag);
                    check_field("mode_now", want.mode_now, result.mode_now);
                end
                rx_wait = eager ? 0 : $urandom_range(0, 9);
            end
            if (hold_left > 0 || rx_wait > 0)
            begin
                result_ready <= 1'b0;
                if (hold_left == 0)
                    rx_wait--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Offer one beat after a random gap, or none when eager, and predict its result on acceptance
    task automatic send_item(in_t s);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        pending_results.push_back(predict_controller(s));
    endtask

    // Drop valid and hold until every predicted result has arrived, then wait a settling gap
    task automatic drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRUST_LAW: law_sel = val[0];
            CFG_PID_P:      gain_p = val[15:0];
            CFG_PID_I:      gain_i = val[15:0];
            CFG_PID_D:      gain_d = val[15:0];
            CFG_TDC_M:      tdc_m = val[15:0];
            CFG_TDC_K:      tdc_k = val[15:0];
            CFG_TDC_V:      tdc_v = val[15:0];
            default:        jump_sq = val;
        endcase
    endtask

    task automatic configure(logic law, logic [15:0] p, logic [15:0] i, logic [15:0] d,
                             logic [15:0] m, logic [15:0] k, logic [15:0] v,
                             logic [31:0] jmp);
        drain();
        write_reg(CFG_THRUST_LAW, {31'd0, law});
        write_reg(CFG_PID_P, {16'd0, p});
        write_reg(CFG_PID_I, {16'd0, i});
        write_reg(CFG_PID_D, {16'd0, d});
        write_reg(CFG_TDC_M, {16'd0, m});
        write_reg(CFG_TDC_K, {16'd0, k});
        write_reg(CFG_TDC_V, {16'd0, v});
        write_reg(CFG_JUMP_SQ, jmp);
    endtask

    function automatic in_t mode_item(int m);
        in_t s;
        s = '0;
        s.command = CMD_SET_MODE;
        s.new_mode = 4'(m);
        return s;
    endfunction

    function automatic in_t pose_item(longint x, longint y, longint z, longint hd);
        in_t s;
        s = '0;
        s.command = CMD_SAMPLE;
        s.pos_x = 16'(x);
        s.pos_y = 16'(y);
        s.pos_z = 16'(z);
        s.heading = 16'(hd);
        s.sample_ok = 1'b1;
        return s;
    endfunction

    // Fully random beat: every field over its whole width
    function automatic in_t noise_item();
        in_t s;
        s.command = ($urandom_range(0, 7) == 0);
        s.new_mode = 4'($urandom);
        s.pos_x = 16'($urandom);
        s.pos_y = 16'($urandom);
        s.pos_z = 16'($urandom);
        s.heading = 16'($urandom);
        s.sample_ok = ($urandom_range(0, 9) != 0);
        return s;
    endfunction

    // Approach run: enter a mode, then feed poses, mostly near the current mode's target
    task automatic approach(int m, int n);
        longint ty, tz, lim;
        bit     yaw, recal;
        int     nxt;
        int     r;
        send_item(mode_item(m));
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 19);
            if (!mode_row(ctl_mode, ty, tz, lim, yaw, recal, nxt))
            begin
                ty = 0;
                tz = 0;
            end
            if (r == 0)
                send_item(noise_item());
            else if (r == 1)
                send_item(pose_item($urandom_range(0, 2000), ty + 900, tz - 700, 0));
            else
                send_item(pose_item(int'($urandom_range(0, 300)) - 150,
                                    ty + int'($urandom_range(0, 300)) - 150,
                                    tz + int'($urandom_range(0, 300)) - 150,
                                    (r < 4) ? int'($urandom_range(0, 200)) - 100
                                            : int'($urandom_range(0, 80)) - 40));
        end
    endtask

    task automatic test_directed();
        in_t s;
        send_item(pose_item(0, 0, 0, 0));
        send_item(mode_item(7));
        send_item(mode_item(-8));
        send_item(mode_item(5));
        s = pose_item(100, 100, 100, 0);
        s.sample_ok = 1'b0;
        send_item(s);
        for (int m = MODE_HOLD_LOW; m <= MODE_DEPLOY; m++)
        begin
            send_item(mode_item(m));
            send_item(pose_item(32767, -32768, 32767, 41));
            send_item(pose_item(-32768, 32767, -32768, -41));
            send_item(pose_item(0, 164, 2458, 40));
        end
    endtask

    // Warm up and run every mode path with a plain PID setting
    task automatic test_pid_modes();
        configure(1'b0, 16'd256, 16'd4, 16'd32, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
        approach(MODE_ALIGN, 45);
        approach(MODE_NEAR, 75);
        approach(MODE_HOLD_HIGH, 30);
        approach(MODE_HOLD_LOW, 30);
        approach(MODE_DEPLOY, 3);
    endtask

    // Outlier gate: tight limit with large jumps after warmup, then limit of zero
    task automatic test_outlier_gate();
        configure(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'h0010_0000);
        approach(MODE_HOLD_HIGH, 20);
        for (int j = 0; j < 15; j++)
            send_item(pose_item(int'($urandom_range(0, 4000)) - 2000, 410, 5325, 0));
        configure(1'b0, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0);
        approach(MODE_NEAR, 30);
    endtask

    task automatic test_tdc_modes();
        configure(1'b1, 16'd0, 16'd0, 16'd0, 16'd128, 16'd512, 16'd64, 32'hFFFF_FFFF);
        approach(MODE_HOLD_LOW, 35);
        approach(MODE_NEAR, 80);
        configure(1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0100_0000);
        approach(MODE_HOLD_HIGH, 30);
        approach(MODE_ALIGN, 40);
    endtask

    // Stall results for a long stretch while beats keep coming, then pause the sender
    task automatic test_backpressure();
        hold_left = 400;
        eager = 1'b1;
        for (int j = 0; j < 20; j++)
            send_item(pose_item(0, 164, 2458, 0));
        eager = 1'b0;
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 3; ph++)
        begin
            configure(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom_range(0, 64)),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      (ph == 1) ? 32'd0 : $urandom);
            eager = (ph == 2);
            approach(MODE_NEAR, 70);
            approach(int'($urandom_range(0, 6)) - 2, 30);
            for (int j = 0; j < 30; j++)
                send_item(noise_item());
        end
        eager = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        failed = 1'b0;
        cycle_cnt = 0;
        eager = 1'b0;
        hold_left = 0;
        rx_wait = 0;
        reset_controller();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pid_modes();
        test_outlier_gate();
        test_backpressure();
        test_tdc_modes();
        test_random();

        drain();
        if (!failed)
            $display("marker_approach_thrust_controller test passed");
        else
            $display("marker_approach_thrust_controller test failed");
        $finish;
    end
endmodule

[sim.f]
rtl/core/matc_pkg.sv
rtl/core/matc_ctrl.sv
rtl/core/matc_dp.sv
rtl/core/marker_approach_thrust_controller.sv
rtl/core/matc_checker.sv
bench/marker_approach_thrust_controller_tb.sv
